// File: rtl/gtp_pkg.sv
// Shared types, constants and helper functions for the go-to-point drive controller.
`default_nettype none
package gtp_pkg;

    // Operations of the serial arithmetic unit
    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic                start;
        t_alu_op             op;
        logic signed [63:0]  a;
        logic signed [63:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic                done;
        logic signed [63:0]  res;
    } t_alu_rsp;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_INTG,
        ST_CORD,
        ST_BMUL,
        ST_BDIV,
        ST_TMUL1,
        ST_TMUL2,
        ST_TDIV,
        ST_FMUL1,
        ST_FMUL2,
        ST_FMUL3,
        ST_FSCL,
        ST_TSCL,
        ST_LMUL,
        ST_LDIV,
        ST_RMUL,
        ST_RDIV,
        ST_FIN
    } t_state;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARGET_X    = 2'd0;
    localparam logic [1:0] CFG_TARGET_Y    = 2'd1;
    localparam logic [1:0] CFG_POWER_SCALE = 2'd2;

    localparam logic [6:0]         POWER_SCALE_RST = 7'd100;
    localparam logic [23:0]        INTEG_MAX       = 24'd13107200;
    localparam logic signed [63:0] PWR_LIMIT       = 64'sd6553600000;
    localparam logic signed [63:0] PWR_DIV         = 64'sd655360000000;
    localparam logic signed [19:0] HALF_PI_Q16     = 20'sd102944;
    localparam logic [34:0]        ARRIVE_R2       = 35'd3136;
    localparam logic signed [16:0] ARRIVE_AXIS     = 17'sd48;
    localparam logic signed [63:0] INTG_ROUND      = 64'sd125;
    localparam logic signed [63:0] INTG_DIV        = 64'sd250;
    localparam logic signed [63:0] BEAR_MUL        = 64'sd288000;
    localparam logic signed [63:0] BEAR_DIV        = 64'sd20578304;
    localparam logic signed [17:0] BEAR_OFFSET     = 18'sd1440;
    localparam logic signed [63:0] TURN_GAIN       = 64'sd11059200;
    localparam logic signed [63:0] FWD_P_GAIN      = 64'sd2713600;
    localparam logic signed [63:0] FWD_I_GAIN      = 64'sd29;
    localparam logic signed [63:0] FWD_D_GAIN      = 64'sd32256000;
    localparam logic signed [63:0] MIX_FWD         = 64'sd70;
    localparam logic signed [63:0] MIX_TURN        = 64'sd105;

    // Arctangent of 2^-i in 2^-16 rad
    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] v;
        begin
            case (i)
                4'd0:    v = 16'd51472;
                4'd1:    v = 16'd30386;
                4'd2:    v = 16'd16055;
                4'd3:    v = 16'd8150;
                4'd4:    v = 16'd4091;
                4'd5:    v = 16'd2047;
                4'd6:    v = 16'd1024;
                4'd7:    v = 16'd512;
                4'd8:    v = 16'd256;
                4'd9:    v = 16'd128;
                4'd10:   v = 16'd64;
                4'd11:   v = 16'd32;
                4'd12:   v = 16'd16;
                4'd13:   v = 16'd8;
                4'd14:   v = 16'd4;
                4'd15:   v = 16'd2;
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [63:0] lim);
        logic signed [63:0] r;
        begin
            if (v > lim)
                r = lim;
            else if (v < -lim)
                r = -lim;
            else
                r = v;
            return r;
        end
    endfunction

    function automatic logic signed [7:0] clamp100(input logic signed [63:0] v);
        logic signed [7:0] r;
        begin
            if (v > 64'sd100)
                r = 8'sd100;
            else if (v < -64'sd100)
                r = -8'sd100;
            else
                r = v[7:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/gtp_alu.sv
// Bit-serial multiply, divide and square root unit shared by the controller sequencer.
`default_nettype none
module gtp_alu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gtp_pkg::t_alu_req i_req,
    output gtp_pkg::t_alu_rsp      o_rsp
);

    logic                r_run, n_run;
    gtp_pkg::t_alu_op    r_op, n_op;
    logic                r_neg, n_neg;
    logic [63:0]         r_ua, n_ua;
    logic [63:0]         r_ub, n_ub;
    logic [64:0]         r_acc, n_acc;
    logic [5:0]          r_cnt, n_cnt;
    logic                r_done, n_done;
    logic signed [63:0]  r_res, n_res;

    logic [64:0] w_trial;
    logic [63:0] w_quo;
    logic [64:0] w_sq_sum;

    // Step the selected operation by one bit
    always_comb begin
        n_run  = r_run;
        n_op   = r_op;
        n_neg  = r_neg;
        n_ua   = r_ua;
        n_ub   = r_ub;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_res  = r_res;
        w_trial  = {r_acc[63:0], r_ua[63]};
        w_quo    = {r_ua[62:0], 1'b0};
        w_sq_sum = r_acc + {1'b0, r_ub};

        if (!r_run) begin
            if (i_req.start) begin
                n_run = 1'b1;
                n_op  = i_req.op;
                n_neg = i_req.a[63] ^ i_req.b[63];
                n_acc = 65'd0;
                n_cnt = 6'd0;
                if (i_req.op == gtp_pkg::ALU_SQRT) begin
                    n_ua = i_req.a;
                    n_ub = 64'h4000_0000_0000_0000;
                end else begin
                    n_ua = i_req.a[63] ? 64'(-i_req.a) : 64'(i_req.a);
                    n_ub = i_req.b[63] ? 64'(-i_req.b) : 64'(i_req.b);
                end
            end
        end else begin
            case (r_op)
                gtp_pkg::ALU_MUL: begin
                    if (r_ub == 64'd0) begin
                        n_run  = 1'b0;
                        n_done = 1'b1;
                        n_res  = r_neg ? -$signed(r_acc[63:0]) : $signed(r_acc[63:0]);
                    end else begin
                        if (r_ub[0])
                            n_acc = r_acc + {1'b0, r_ua};
                        n_ua = {r_ua[62:0], 1'b0};
                        n_ub = {1'b0, r_ub[63:1]};
                    end
                end
                gtp_pkg::ALU_DIV: begin
                    if (w_trial >= {1'b0, r_ub}) begin
                        n_acc = w_trial - {1'b0, r_ub};
                        w_quo = {r_ua[62:0], 1'b1};
                    end else begin
                        n_acc = w_trial;
                    end
                    n_ua  = w_quo;
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        n_run  = 1'b0;
                        n_done = 1'b1;
                        n_res  = r_neg ? -$signed(w_quo) : $signed(w_quo);
                    end
                end
                gtp_pkg::ALU_SQRT: begin
                    if (r_ub == 64'd0) begin
                        n_run  = 1'b0;
                        n_done = 1'b1;
                        n_res  = $signed(r_acc[63:0]);
                    end else begin
                        if ({1'b0, r_ua} >= w_sq_sum) begin
                            n_ua  = r_ua - w_sq_sum[63:0];
                            n_acc = {1'b0, r_acc[64:1]} + {1'b0, r_ub};
                        end else begin
                            n_acc = {1'b0, r_acc[64:1]};
                        end
                        n_ub = {2'b00, r_ub[63:2]};
                    end
                end
                default: begin
                    n_run = 1'b0;
                end
            endcase
        end
    end

    // Hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    // Advance operand and result registers
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_neg <= n_neg;
        r_ua  <= n_ua;
        r_ub  <= n_ub;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule
`default_nettype wire

// File: rtl/go_to_point_drive_controller.sv
// Top level of the go-to-point differential drive controller.
//
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tdata: pos_x, pos_y, heading; tuser: start_req
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: pwr_left, pwr_right; tuser: arrived
// cfg      in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// An idle tick (done and no start) goes from idle straight to the final state. A driving
// tick is set by the one-bit-per-cycle multiply/divide/square-root unit: five 64-step divides
// and a 32-step square root dominate, plus a 16-step CORDIC for the bearing.
// An arrival tick ends after the integral divide.
// Reset (synchronous, active low) clears the state to done with targets 0 and scale 100.
// A finished result waits in the output register; the next item is taken meanwhile and
// its result holds in the final state until the output register frees up.
`default_nettype none
module go_to_point_drive_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], heading[47:32]
    input  wire logic        s_axis_tuser,   // start_req
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // pwr_left[7:0], pwr_right[15:8]
    output logic             m_axis_tuser,   // arrived
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    gtp_pkg::t_state     r_state, n_state;
    logic                r_wait, n_wait;
    logic signed [15:0]  r_tx, n_tx;
    logic signed [15:0]  r_ty, n_ty;
    logic [6:0]          r_ps, n_ps;
    logic [21:0]         r_start_d, n_start_d;
    logic [23:0]         r_integ, n_integ;
    logic [21:0]         r_prev, n_prev;
    logic                r_done, n_done;
    logic signed [16:0]  r_dx, n_dx;
    logic signed [16:0]  r_dy, n_dy;
    logic signed [15:0]  r_hd, n_hd;
    logic                r_st, n_st;
    logic [34:0]         r_r2, n_r2;
    logic [21:0]         r_d, n_d;
    logic signed [63:0]  r_acc, n_acc;
    logic signed [63:0]  r_fwd, n_fwd;
    logic signed [63:0]  r_turn, n_turn;
    logic signed [27:0]  r_cx, n_cx;
    logic signed [27:0]  r_cy, n_cy;
    logic signed [19:0]  r_z, n_z;
    logic [3:0]          r_i, n_i;
    logic signed [17:0]  r_t16, n_t16;
    logic signed [7:0]   r_rl, n_rl;
    logic signed [7:0]   r_rr, n_rr;
    logic                r_ra, n_ra;
    logic                r_ov, n_ov;
    logic signed [7:0]   r_ol, n_ol;
    logic signed [7:0]   r_or, n_or;
    logic                r_oa, n_oa;

    gtp_pkg::t_alu_req w_req;
    gtp_pkg::t_alu_rsp w_rsp;

    logic signed [27:0] w_x0, w_y0, w_xs, w_ys;
    logic [24:0]        w_isum;
    logic [21:0]        w_d0, w_diff;
    logic signed [63:0] w_sres;

    gtp_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_x0   = {r_dx[16], r_dx[16], r_dx[16], r_dx, 8'd0};
    assign w_y0   = {r_dy[16], r_dy[16], r_dy[16], r_dy, 8'd0};
    assign w_xs   = r_cx >>> r_i;
    assign w_ys   = r_cy >>> r_i;
    assign w_d0   = (r_start_d != 22'd0) ? r_start_d : r_d;
    assign w_diff = (r_d >= r_prev) ? (r_d - r_prev) : (r_prev - r_d);
    assign w_sres = w_rsp.res;
    assign w_isum = {1'b0, r_integ} + {6'd0, w_sres[18:0]};

    // Sequence one tick through the shared arithmetic unit
    always_comb begin
        n_state   = r_state;
        n_wait    = r_wait;
        n_tx      = r_tx;
        n_ty      = r_ty;
        n_ps      = r_ps;
        n_start_d = r_start_d;
        n_integ   = r_integ;
        n_prev    = r_prev;
        n_done    = r_done;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_hd      = r_hd;
        n_st      = r_st;
        n_r2      = r_r2;
        n_d       = r_d;
        n_acc     = r_acc;
        n_fwd     = r_fwd;
        n_turn    = r_turn;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_z       = r_z;
        n_i       = r_i;
        n_t16     = r_t16;
        n_rl      = r_rl;
        n_rr      = r_rr;
        n_ra      = r_ra;
        n_ov      = r_ov;
        n_ol      = r_ol;
        n_or      = r_or;
        n_oa      = r_oa;
        w_req.start = 1'b0;
        w_req.op    = gtp_pkg::ALU_MUL;
        w_req.a     = 64'sd0;
        w_req.b     = 64'sd0;

        // Configuration writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                gtp_pkg::CFG_TARGET_X:    n_tx = $signed(i_cfg_data);
                gtp_pkg::CFG_TARGET_Y:    n_ty = $signed(i_cfg_data);
                gtp_pkg::CFG_POWER_SCALE: n_ps = i_cfg_data[6:0];
                default: ;
            endcase
        end

        // Drop the output item once taken
        if (r_ov && m_axis_tready)
            n_ov = 1'b0;

        case (r_state)
            gtp_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_dx = 17'($signed(s_axis_tdata[15:0])) - 17'(r_tx);
                    n_dy = 17'($signed(s_axis_tdata[31:16])) - 17'(r_ty);
                    n_hd = $signed(s_axis_tdata[47:32]);
                    n_st = s_axis_tuser;
                    if (r_done && !s_axis_tuser) begin
                        n_rl    = 8'sd0;
                        n_rr    = 8'sd0;
                        n_ra    = 1'b1;
                        n_state = gtp_pkg::ST_FIN;
                    end else begin
                        n_state = gtp_pkg::ST_SQX;
                    end
                end
            end
            gtp_pkg::ST_SQX: begin
                w_req.a = 64'(r_dx);
                w_req.b = 64'(r_dx);
                if (w_rsp.done) begin
                    n_acc   = w_sres;
                    n_state = gtp_pkg::ST_SQY;
                end
            end
            gtp_pkg::ST_SQY: begin
                w_req.a = 64'(r_dy);
                w_req.b = 64'(r_dy);
                if (w_rsp.done) begin
                    n_r2    = r_acc[34:0] + w_sres[34:0];
                    n_state = gtp_pkg::ST_SQRT;
                end
            end
            gtp_pkg::ST_SQRT: begin
                w_req.op = gtp_pkg::ALU_SQRT;
                w_req.a  = $signed({21'd0, r_r2, 8'd0});
                if (w_rsp.done) begin
                    n_d = w_sres[21:0];
                    if (r_st) begin
                        n_start_d = w_sres[21:0];
                        n_integ   = 24'd0;
                        n_prev    = 22'd0;
                        n_done    = 1'b0;
                    end
                    n_state = gtp_pkg::ST_INTG;
                end
            end
            gtp_pkg::ST_INTG: begin
                w_req.op = gtp_pkg::ALU_DIV;
                w_req.a  = $signed({36'd0, r_d, 6'd0}) + gtp_pkg::INTG_ROUND;
                w_req.b  = gtp_pkg::INTG_DIV;
                if (w_rsp.done) begin
                    n_integ = (w_isum > {1'b0, gtp_pkg::INTEG_MAX}) ?
                              gtp_pkg::INTEG_MAX : w_isum[23:0];
                    if (r_r2 < gtp_pkg::ARRIVE_R2 ||
                        (r_dx < gtp_pkg::ARRIVE_AXIS && r_dx > -gtp_pkg::ARRIVE_AXIS) ||
                        (r_dy < gtp_pkg::ARRIVE_AXIS && r_dy > -gtp_pkg::ARRIVE_AXIS)) begin
                        n_done  = 1'b1;
                        n_rl    = 8'sd0;
                        n_rr    = 8'sd0;
                        n_ra    = 1'b1;
                        n_state = gtp_pkg::ST_FIN;
                    end else begin
                        // Pre-rotate into the right half plane
                        n_i = 4'd0;
                        if (r_dx < 0) begin
                            if (r_dy >= 0) begin
                                n_cx = w_y0;
                                n_cy = -w_x0;
                                n_z  = gtp_pkg::HALF_PI_Q16;
                            end else begin
                                n_cx = -w_y0;
                                n_cy = w_x0;
                                n_z  = -gtp_pkg::HALF_PI_Q16;
                            end
                        end else begin
                            n_cx = w_x0;
                            n_cy = w_y0;
                            n_z  = 20'sd0;
                        end
                        n_state = gtp_pkg::ST_CORD;
                    end
                end
            end
            gtp_pkg::ST_CORD: begin
                if (r_cy > 0) begin
                    n_cx = r_cx + w_ys;
                    n_cy = r_cy - w_xs;
                    n_z  = r_z + $signed({4'd0, gtp_pkg::atan_q16(r_i)});
                end else begin
                    n_cx = r_cx - w_ys;
                    n_cy = r_cy + w_xs;
                    n_z  = r_z - $signed({4'd0, gtp_pkg::atan_q16(r_i)});
                end
                n_i = r_i + 4'd1;
                if (r_i == 4'd15)
                    n_state = gtp_pkg::ST_BMUL;
            end
            gtp_pkg::ST_BMUL: begin
                w_req.a = 64'(r_z);
                w_req.b = gtp_pkg::BEAR_MUL;
                if (w_rsp.done) begin
                    n_acc   = w_sres;
                    n_state = gtp_pkg::ST_BDIV;
                end
            end
            gtp_pkg::ST_BDIV: begin
                w_req.op = gtp_pkg::ALU_DIV;
                w_req.a  = r_acc;
                w_req.b  = gtp_pkg::BEAR_DIV;
                if (w_rsp.done) begin
                    n_t16   = gtp_pkg::BEAR_OFFSET + w_sres[17:0] - 18'(r_hd);
                    n_state = gtp_pkg::ST_TMUL1;
                end
            end
            gtp_pkg::ST_TMUL1: begin
                w_req.a = gtp_pkg::TURN_GAIN;
                w_req.b = 64'(r_t16);
                if (w_rsp.done) begin
                    n_acc   = w_sres;
                    n_state = gtp_pkg::ST_TMUL2;
                end
            end
            gtp_pkg::ST_TMUL2: begin
                w_req.a = r_acc;
                w_req.b = $signed({42'd0, r_d});
                if (w_rsp.done) begin
                    n_acc   = w_sres;
                    n_state = gtp_pkg::ST_TDIV;
                end
            end
            gtp_pkg::ST_TDIV: begin
                w_req.op = gtp_pkg::ALU_DIV;
                w_req.a  = r_acc;
                w_req.b  = $signed({42'd0, w_d0});
                if (w_rsp.done) begin
                    n_turn  = gtp_pkg::clamp64(w_sres, gtp_pkg::PWR_LIMIT);
                    n_state = gtp_pkg::ST_FMUL1;
                end
            end
            gtp_pkg::ST_FMUL1: begin
                w_req.a = gtp_pkg::FWD_P_GAIN;
                w_req.b = $signed({42'd0, r_d});
                if (w_rsp.done) begin
                    n_acc   = w_sres;
                    n_state = gtp_pkg::ST_FMUL2;
                end
            end
            gtp_pkg::ST_FMUL2: begin
                w_req.a = $signed({40'd0, r_integ});
                w_req.b = gtp_pkg::FWD_I_GAIN;
                if (w_rsp.done) begin
                    n_acc   = r_acc + w_sres;
                    n_state = gtp_pkg::ST_FMUL3;
                end
            end
            gtp_pkg::ST_FMUL3: begin
                w_req.a = gtp_pkg::FWD_D_GAIN;
                w_req.b = $signed({42'd0, w_diff});
                if (w_rsp.done) begin
                    n_fwd   = gtp_pkg::clamp64(r_acc - w_sres, gtp_pkg::PWR_LIMIT);
                    n_prev  = r_d;
                    n_state = gtp_pkg::ST_FSCL;
                end
            end
            gtp_pkg::ST_FSCL: begin
                w_req.a = r_fwd;
                w_req.b = gtp_pkg::MIX_FWD;
                if (w_rsp.done) begin
                    n_fwd   = w_sres;
                    n_state = gtp_pkg::ST_TSCL;
                end
            end
            gtp_pkg::ST_TSCL: begin
                w_req.a = r_turn;
                w_req.b = gtp_pkg::MIX_TURN;
                if (w_rsp.done) begin
                    n_turn  = w_sres;
                    n_state = gtp_pkg::ST_LMUL;
                end
            end
            gtp_pkg::ST_LMUL: begin
                w_req.a = r_fwd + r_turn;
                w_req.b = $signed({57'd0, r_ps});
                if (w_rsp.done) begin
                    n_acc   = w_sres;
                    n_state = gtp_pkg::ST_LDIV;
                end
            end
            gtp_pkg::ST_LDIV: begin
                w_req.op = gtp_pkg::ALU_DIV;
                w_req.a  = r_acc;
                w_req.b  = gtp_pkg::PWR_DIV;
                if (w_rsp.done) begin
                    n_rl    = gtp_pkg::clamp100(w_sres);
                    n_state = gtp_pkg::ST_RMUL;
                end
            end
            gtp_pkg::ST_RMUL: begin
                w_req.a = r_fwd - r_turn;
                w_req.b = $signed({57'd0, r_ps});
                if (w_rsp.done) begin
                    n_acc   = w_sres;
                    n_state = gtp_pkg::ST_RDIV;
                end
            end
            gtp_pkg::ST_RDIV: begin
                w_req.op = gtp_pkg::ALU_DIV;
                w_req.a  = r_acc;
                w_req.b  = gtp_pkg::PWR_DIV;
                if (w_rsp.done) begin
                    n_rr    = gtp_pkg::clamp100(w_sres);
                    n_ra    = 1'b0;
                    n_state = gtp_pkg::ST_FIN;
                end
            end
            gtp_pkg::ST_FIN: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_ol    = r_rl;
                    n_or    = r_rr;
                    n_oa    = r_ra;
                    n_state = gtp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gtp_pkg::ST_IDLE;
            end
        endcase

        // Launch the unit once per arithmetic state and wait for its result
        if (r_state != gtp_pkg::ST_IDLE && r_state != gtp_pkg::ST_CORD &&
            r_state != gtp_pkg::ST_FIN && !r_wait) begin
            w_req.start = 1'b1;
            n_wait      = 1'b1;
        end
        if (w_rsp.done)
            n_wait = 1'b0;
    end

    // Hold control and move state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gtp_pkg::ST_IDLE;
            r_wait    <= 1'b0;
            r_tx      <= 16'sd0;
            r_ty      <= 16'sd0;
            r_ps      <= gtp_pkg::POWER_SCALE_RST;
            r_start_d <= 22'd0;
            r_integ   <= 24'd0;
            r_prev    <= 22'd0;
            r_done    <= 1'b1;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wait    <= n_wait;
            r_tx      <= n_tx;
            r_ty      <= n_ty;
            r_ps      <= n_ps;
            r_start_d <= n_start_d;
            r_integ   <= n_integ;
            r_prev    <= n_prev;
            r_done    <= n_done;
            r_ov      <= n_ov;
        end
    end

    // Advance working and output payload registers
    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_hd   <= n_hd;
        r_st   <= n_st;
        r_r2   <= n_r2;
        r_d    <= n_d;
        r_acc  <= n_acc;
        r_fwd  <= n_fwd;
        r_turn <= n_turn;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_z    <= n_z;
        r_i    <= n_i;
        r_t16  <= n_t16;
        r_rl   <= n_rl;
        r_rr   <= n_rr;
        r_ra   <= n_ra;
        r_ol   <= n_ol;
        r_or   <= n_or;
        r_oa   <= n_oa;
    end

    assign s_axis_tready = (r_state == gtp_pkg::ST_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_or, r_ol};
    assign m_axis_tuser  = r_oa;
    assign o_cfg_ready   = 1'b1;

    // Input is taken only with no arithmetic pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_wait)
        else $error("input taken while arithmetic pending");

    // A result from the unit arrives only when one was requested
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_wait)
        else $error("unexpected arithmetic result");

    // Arrival always carries zero powers
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 16'd0))
        else $error("arrival with nonzero power");

    // Integral never exceeds its clamp
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integ <= gtp_pkg::INTEG_MAX)
        else $error("integral above clamp");

endmodule
`default_nettype wire
